@@ hw/rtl/keypad_last_column_priority_unit_assert.svh @@
// assertion macros used by the keypad priority unit
`ifndef KEYPAD_LAST_COLUMN_PRIORITY_UNIT_ASSERT_SVH
`define KEYPAD_LAST_COLUMN_PRIORITY_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define KPLCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define KPLCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kplcp_pkg.sv @@
// ----------------------------------------------------------------------------
// kplcp_pkg
// shared widths, defaults, controller states and control structs for the
// keypad last-column priority unit
// ----------------------------------------------------------------------------
package kplcp_pkg;

    localparam int KEY_W        = 36;
    localparam int LEAD_W       = 4;
    localparam int ROW_MASK_W   = 3;
    localparam int COLS_DEFAULT = 12;
    localparam int ROWS_DEFAULT = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUBLISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic last_col;
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/kplcp_scan_if.sv @@
// ----------------------------------------------------------------------------
// kplcp_scan_if
// input channel: one full key matrix scan per transaction
// ----------------------------------------------------------------------------
interface kplcp_scan_if import kplcp_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] keys;

    modport source (output valid, output keys, input ready);
    modport sink (input valid, input keys, output ready);

endinterface

@@ hw/rtl/kplcp_lead_if.sv @@
// ----------------------------------------------------------------------------
// kplcp_lead_if
// output channel: lead column and its pressed rows per transaction
// ----------------------------------------------------------------------------
interface kplcp_lead_if import kplcp_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [LEAD_W-1:0]     lead_column;
    logic [ROW_MASK_W-1:0] lead_row_mask;

    modport source (output valid, output lead_column, output lead_row_mask, input ready);
    modport sink (input valid, input lead_column, input lead_row_mask, output ready);

endinterface

@@ hw/rtl/kplcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// kplcp_ctrl
// sequencer: takes a scan, walks the columns one per cycle, then publishes
// ----------------------------------------------------------------------------
module kplcp_ctrl import kplcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       scan_valid,
    output logic       scan_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (scan_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.last_col)
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        scan_ready  = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_ready = 1'b1;
                cmd.load   = scan_valid;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            ST_PUBLISH:
            begin
                cmd.publish = status.out_free;
            end
            default:
            begin
                scan_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/kplcp_datapath.sv @@
// ----------------------------------------------------------------------------
// kplcp_datapath
// scan registers, per-column recency ranks, column counter and result register
// ----------------------------------------------------------------------------
module kplcp_datapath import kplcp_pkg::*;
#(
    parameter int COLS = COLS_DEFAULT,
    parameter int ROWS = ROWS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [KEY_W-1:0]      keys,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [LEAD_W-1:0]     lead_column,
    output logic [ROW_MASK_W-1:0] lead_row_mask
);

    localparam int CW = $clog2(COLS);

    logic [KEY_W-1:0]      now_reg;
    logic [KEY_W-1:0]      now_next;
    logic [KEY_W-1:0]      prev_reg;
    logic [KEY_W-1:0]      prev_next;
    logic [CW-1:0]         rank_reg [COLS];
    logic [CW-1:0]         rank_next [COLS];
    logic [CW-1:0]         col_reg;
    logic [CW-1:0]         col_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [LEAD_W-1:0]     lead_reg;
    logic [LEAD_W-1:0]     lead_next;
    logic [ROW_MASK_W-1:0] rows_reg;
    logic [ROW_MASK_W-1:0] rows_next;

    logic [ROWS-1:0]       now_rows [COLS];
    logic [ROWS-1:0]       prev_rows [COLS];
    logic                  is_on;
    logic                  was_on;
    logic [CW-1:0]         cur_rank;
    logic [CW-1:0]         lead_idx;
    logic                  lead_found;
    logic [ROWS-1:0]       lead_rows;

    // unpack the scans into per-column row bits; bits past the port width read 0
    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        for (genvar r = 0; r < ROWS; r++)
        begin : g_row
            if (r * COLS + c < KEY_W)
            begin : g_in
                assign now_rows[c][r]  = now_reg[r * COLS + c];
                assign prev_rows[c][r] = prev_reg[r * COLS + c];
            end
            else
            begin : g_out
                assign now_rows[c][r]  = 1'b0;
                assign prev_rows[c][r] = 1'b0;
            end
        end
    end

    assign is_on    = |now_rows[col_reg];
    assign was_on   = |prev_rows[col_reg];
    assign cur_rank = rank_reg[col_reg];

    // move-to-front on press, move-to-back on release, for the current column
    always_comb
    begin
        for (int i = 0; i < COLS; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.step && is_on && !was_on)
        begin
            for (int i = 0; i < COLS; i++)
            begin
                if (rank_reg[i] < cur_rank)
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            rank_next[col_reg] = '0;
        end
        else if (cmd.step && was_on && !is_on)
        begin
            for (int i = 0; i < COLS; i++)
            begin
                if (rank_reg[i] > cur_rank)
                begin
                    rank_next[i] = rank_reg[i] - 1'b1;
                end
            end
            rank_next[col_reg] = CW'(COLS - 1);
        end
    end

    // lowest-index column holding rank zero
    always_comb
    begin
        lead_idx   = '0;
        lead_found = 1'b0;
        for (int i = COLS - 1; i >= 0; i--)
        begin
            if (rank_reg[i] == '0)
            begin
                lead_idx   = CW'(i);
                lead_found = 1'b1;
            end
        end
    end

    assign lead_rows = lead_found ? now_rows[lead_idx] : '0;

    always_comb
    begin
        now_next       = now_reg;
        prev_next      = prev_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        lead_next      = lead_reg;
        rows_next      = rows_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            now_next = keys;
            col_next = '0;
        end
        if (cmd.step)
        begin
            col_next = col_reg + 1'b1;
        end
        if (cmd.publish)
        begin
            prev_next      = now_reg;
            out_valid_next = 1'b1;
            lead_next      = LEAD_W'(lead_idx);
            for (int r = 0; r < ROW_MASK_W; r++)
            begin
                rows_next[r] = (r < ROWS) ? lead_rows[r % ROWS] : 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < COLS; i++)
            begin
                rank_reg[i] <= CW'(i);
            end
        end
        else
        begin
            prev_reg      <= prev_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < COLS; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        lead_reg <= lead_next;
        rows_reg <= rows_next;
    end

    assign status.last_col = (col_reg == CW'(COLS - 1));
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign lead_column     = lead_reg;
    assign lead_row_mask   = rows_reg;

endmodule

@@ hw/rtl/keypad_last_column_priority_unit.sv @@
// a taken scan is loaded, its columns are walked, then the lead result is registered
// a new scan is taken only once the previous result is published; the column walk
//   updates the recency ranks one column per cycle
// a waiting result sits in the output register while the next scan is taken
// reset (rst_n low, async): previous scan cleared, column ranks set to index
`include "keypad_last_column_priority_unit_assert.svh"
// ----------------------------------------------------------------------------
// keypad_last_column_priority_unit
// tracks column press recency and reports the most recent active column
// ----------------------------------------------------------------------------
module keypad_last_column_priority_unit import kplcp_pkg::*;
#(
    parameter int COLS = COLS_DEFAULT,
    parameter int ROWS = ROWS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    kplcp_scan_if.sink    scan,
    kplcp_lead_if.source  lead
);

    dp_cmd_t    cmd;
    dp_status_t status;

    kplcp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan.valid),
        .scan_ready (scan.ready),
        .status     (status),
        .cmd        (cmd)
    );

    kplcp_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .keys          (scan.keys),
        .out_ready     (lead.ready),
        .out_valid     (lead.valid),
        .lead_column   (lead.lead_column),
        .lead_row_mask (lead.lead_row_mask)
    );

    // no new scan while one is in flight
    `KPLCP_ASSERT_NEXT(a_busy_after_load, scan.valid && scan.ready, !scan.ready, "scan taken while busy")
    // a result is only written into a free output register
    `KPLCP_ASSERT_NOW(a_publish_free, cmd.publish, status.out_free, "result overwrote pending result")
    // walk and publish never overlap a load
    `KPLCP_ASSERT_NOW(a_cmd_exclusive, cmd.step || cmd.publish, !cmd.load, "load during column walk")
    // lead column always names a real column
    `KPLCP_ASSERT_NOW(a_lead_range, lead.valid, lead.lead_column < LEAD_W'(COLS), "lead column out of range")

endmodule

@@ dv/kplcp_lead_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kplcp_lead_checker
// watches the scan and lead channels, tracks column recency ranks on every
// accepted scan and compares each lead result against the oldest expectation
// ----------------------------------------------------------------------------
module kplcp_lead_checker import kplcp_pkg::*;
#(
    parameter int COLS = COLS_DEFAULT,
    parameter int ROWS = ROWS_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    kplcp_scan_if scan,
    kplcp_lead_if lead,
    output int    mismatches,
    output int    outstanding,
    output int    results_checked
);

    typedef struct packed {
        logic [LEAD_W-1:0]     column;
        logic [ROW_MASK_W-1:0] rows;
    } lead_t;

    logic [KEY_W-1:0]  last_scan;
    logic [LEAD_W-1:0] col_rank [COLS];
    lead_t             pending_leads [$];
    lead_t             want;

    function automatic logic column_on(input logic [KEY_W-1:0] k, input int c);
        logic on;
        on = 1'b0;
        for (int r = 0; r < ROWS; r++)
            on |= k[r*COLS + c];
        return on;
    endfunction

    // update the recency ranks for one scan and work out the lead result
    function automatic lead_t rank_columns(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0]  now;
        logic [LEAD_W-1:0] cur;
        logic              is_on;
        logic              was_on;
        lead_t             res;
        now = raw;
        for (int b = ROWS*COLS; b < KEY_W; b++)
            now[b] = 1'b0;
        for (int c = 0; c < COLS; c++)
        begin
            is_on  = column_on(now, c);
            was_on = column_on(last_scan, c);
            cur    = col_rank[c];
            if (is_on && !was_on)
            begin
                for (int i = 0; i < COLS; i++)
                    if (col_rank[i] < cur) col_rank[i] = col_rank[i] + 1'b1;
                col_rank[c] = '0;
            end
            if (was_on && !is_on)
            begin
                for (int i = 0; i < COLS; i++)
                    if (col_rank[i] > cur) col_rank[i] = col_rank[i] - 1'b1;
                col_rank[c] = LEAD_W'(COLS - 1);
            end
        end
        last_scan = now;
        res = '0;
        for (int c = COLS - 1; c >= 0; c--)
            if (col_rank[c] == '0) res.column = LEAD_W'(c);
        if (col_rank[res.column] == '0)
            for (int r = 0; r < ROWS && r < ROW_MASK_W; r++)
                res.rows[r] = now[r*COLS + res.column];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_scan = '0;
            for (int c = 0; c < COLS; c++)
                col_rank[c] = LEAD_W'(c);
            pending_leads.delete();
            mismatches      = 0;
            results_checked = 0;
        end
        else
        begin
            // results first so a same-edge scan cannot satisfy an early result
            if (lead.valid && lead.ready)
            begin
                results_checked++;
                if (pending_leads.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected lead transaction col=%0d rows=%b",
                                 $realtime, lead.lead_column, lead.lead_row_mask);
                end
                else
                begin
                    want = pending_leads.pop_front();
                    if (lead.lead_column !== want.column || lead.lead_row_mask !== want.rows)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: lead mismatch exp col=%0d rows=%b got col=%0d rows=%b",
                                     $realtime, want.column, want.rows,
                                     lead.lead_column, lead.lead_row_mask);
                    end
                end
            end
            if (scan.valid && scan.ready)
                pending_leads.push_back(rank_columns(scan.keys));
        end
        outstanding = pending_leads.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives key matrix scans into the last-column priority unit with random
// gaps and output stalls, and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_top;
    import kplcp_pkg::*;

    localparam int COLS        = COLS_DEFAULT;
    localparam int ROWS        = ROWS_DEFAULT;
    localparam int RAND_SCANS  = 1500;
    localparam int HOLD_START  = 3000;
    localparam int HOLD_LEN    = 300;
    localparam int STEADY_LO   = 10000;
    localparam int STEADY_HI   = 14000;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN       = 4 * (COLS + 2);

    logic clk = 1'b0;
    logic rst_n;

    int   mismatches;
    int   outstanding;
    int   results_checked;
    int   scans_sent;
    int   stall_cycles = 0;
    logic steady_sender;

    kplcp_scan_if scan_ch ();
    kplcp_lead_if lead_ch ();

    keypad_last_column_priority_unit #(.COLS(COLS), .ROWS(ROWS)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan_ch),
        .lead  (lead_ch)
    );

    kplcp_lead_checker #(.COLS(COLS), .ROWS(ROWS)) lead_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .scan            (scan_ch),
        .lead            (lead_ch),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] random_keys();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[KEY_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] key_bit(input int r, input int c);
        logic [KEY_W-1:0] k;
        k = '0;
        k[r*COLS + c] = 1'b1;
        return k;
    endfunction

    // offer one scan, hold it until taken, then maybe leave a gap
    task automatic send_scan(input logic [KEY_W-1:0] k);
        scan_ch.valid <= 1'b1;
        scan_ch.keys  <= k;
        @(posedge clk);
        while (!scan_ch.ready)
            @(posedge clk);
        scans_sent++;
        while (!steady_sender && $urandom_range(99) < 24)
        begin
            scan_ch.valid <= 1'b0;
            scan_ch.keys  <= random_keys();
            @(posedge clk);
        end
    endtask

    // output side: random stalls, one long hold-off, one stretch always ready
    initial
    begin
        int unsigned cyc;
        lead_ch.ready <= 1'b0;
        @(posedge rst_n);
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                lead_ch.ready <= 1'b0;
            else if (cyc >= STEADY_LO && cyc < STEADY_HI)
                lead_ch.ready <= 1'b1;
            else
                lead_ch.ready <= ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (scan_ch.valid && scan_ch.ready) || (lead_ch.valid && lead_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $realtime, stall_cycles);
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [KEY_W-1:0] held;
        logic [KEY_W-1:0] col11_all;
        int               sel;
        int               idx;
        rst_n         <= 1'b0;
        scan_ch.valid <= 1'b0;
        scan_ch.keys  <= '0;
        steady_sender  = 1'b0;
        scans_sent     = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, full, release all, a single key walking across columns
        send_scan('0);
        send_scan('1);
        send_scan('0);
        for (int c = 0; c < COLS; c++)
            send_scan(key_bit(c % ROWS, c));
        col11_all = '0;
        for (int r = 0; r < ROWS; r++)
            col11_all |= key_bit(r, COLS - 1);
        send_scan(col11_all);
        // low column pressed while the top column stays held
        send_scan(col11_all | key_bit(1, 0));
        send_scan(col11_all);
        send_scan(key_bit(0, 0) | key_bit(ROWS - 1, COLS - 1));
        send_scan('0);

        // random: mostly a few keys toggled per scan, plus noise
        held = '0;
        for (int n = 0; n < RAND_SCANS; n++)
        begin
            steady_sender = (n >= 700 && n < 1000);
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    idx = $urandom_range(KEY_W - 1);
                    held[idx] = ~held[idx];
                end
            end
            else if (sel < 85)
                held = random_keys();
            else if (sel < 95)
                held = '0;
            else if (sel < 98)
                held = '1;
            send_scan(held);
        end
        scan_ch.valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("run covered %0d scans and %0d lead results, with a %0d-cycle output hold-off",
                 scans_sent, results_checked, HOLD_LEN);
        $display("mismatches: %0d, results still expected: %0d", mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
